/* hdl/ntt_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// ntt_pkg: shared types and constants of the nearest target tracker
// Field widths, register indexes, queue entry layout and helper functions.
// ============================================================================
package ntt_pkg;

    // Trajectory depth and derived counter width.
    localparam int HISTORY_DEPTH = 30;
    localparam int PH_W          = $clog2(HISTORY_DEPTH + 1);

    // Field widths.
    localparam int COORD_W  = 12;
    localparam int POS_W    = 13;
    localparam int DIST_W   = 24;
    localparam int DEPTH_W  = 25;
    localparam int PROD_W   = 2 * DIST_W;
    localparam int GAP_W    = 50;
    localparam int COUNT_W  = 8;
    localparam int CLASS_W  = 2;
    localparam int HLEN_W   = 5;
    localparam int HLEN_MAX = (1 << HLEN_W) - 1;
    localparam int DIV_CNT_W = $clog2(DIST_W + 1);

    // Stream payload widths.
    localparam int S_TDATA_W     = 48;
    localparam int OUT_FIELDS_W  = 85;
    localparam int M_TDATA_W     = 88;

    // Queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_SCALE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MISS_LIMIT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_THRESHOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MID_THRESHOLD  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_ORIGIN   = 3'd4;

    localparam logic [DIST_W-1:0]  RST_DISTANCE_SCALE = 24'd90000;
    localparam logic [COUNT_W-1:0] RST_MISS_LIMIT     = 8'd15;
    localparam logic [DIST_W-1:0]  RST_NEAR_THRESHOLD = 24'd300;
    localparam logic [DIST_W-1:0]  RST_MID_THRESHOLD  = 24'd550;
    localparam logic [DIST_W-1:0]  RST_DEPTH_ORIGIN   = 24'd500;

    // Distance classes.
    localparam logic [CLASS_W-1:0] CLASS_NEAR = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_MID  = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_FAR  = 2'd2;

    // What a queued item asks the back end to do.
    typedef enum logic [1:0] {
        KIND_BOX,
        KIND_BOX_LAST,
        KIND_CLOSE
    } item_kind_t;

    typedef struct packed {
        item_kind_t         kind;
        logic [POS_W-1:0]   cx;
        logic [POS_W-1:0]   cy;
        logic [COORD_W-1:0] width;
    } queue_entry_t;

    typedef struct packed {
        logic [DIST_W-1:0]  distance_scale;
        logic [COUNT_W-1:0] miss_limit;
        logic [DIST_W-1:0]  near_threshold;
        logic [DIST_W-1:0]  mid_threshold;
        logic [DIST_W-1:0]  depth_origin;
    } cfg_t;

    typedef struct packed {
        logic               start;
        logic [DIST_W-1:0]  dividend;
        logic [COORD_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIST_W-1:0] quotient;
    } div_rsp_t;

    function automatic logic [DIST_W-1:0] abs_diff(input logic [DIST_W-1:0] a,
                                                   input logic [DIST_W-1:0] b);
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [HLEN_W-1:0] hist_len(input logic [PH_W-1:0] ph);
        if (32'(ph) > 32'(HLEN_MAX)) begin
            hist_len = HLEN_W'(HLEN_MAX);
        end else begin
            hist_len = HLEN_W'(ph);
        end
    endfunction

endpackage

/* hdl/ntt_front.sv */
`timescale 1ns / 1ps
// ============================================================================
// ntt_front: request intake and classification
// Registers each input request, classifies it and forms the box centre.
// ============================================================================
module ntt_front import ntt_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    input  logic                 s_tlast,
    output logic                 push_valid,
    input  logic                 push_ready,
    output queue_entry_t         push_entry
);

    logic               stage_valid_reg;
    queue_entry_t       entry_reg;
    queue_entry_t       entry_next;
    logic [COORD_W-1:0] bx, by, bw, bh;

    assign bx = s_tdata[11:0];
    assign by = s_tdata[23:12];
    assign bw = s_tdata[35:24];
    assign bh = s_tdata[47:36];

    assign s_tready   = !stage_valid_reg || push_ready;
    assign push_valid = stage_valid_reg;
    assign push_entry = entry_reg;

    // An empty item always closes the frame, whatever its last flag says.
    always_comb begin
        if (s_tuser) begin
            entry_next.kind = KIND_CLOSE;
        end else if (s_tlast) begin
            entry_next.kind = KIND_BOX_LAST;
        end else begin
            entry_next.kind = KIND_BOX;
        end
        entry_next.cx    = {1'b0, bx} + {2'b00, bw[COORD_W-1:1]};
        entry_next.cy    = {1'b0, by} + {2'b00, bh[COORD_W-1:1]};
        entry_next.width = (bw == '0) ? COORD_W'(1) : bw;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            stage_valid_reg <= 1'b1;
        end else if (push_ready) begin
            stage_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            entry_reg <= entry_next;
        end
    end

endmodule

/* hdl/ntt_queue.sv */
`timescale 1ns / 1ps
// ============================================================================
// ntt_queue: short queue between front and back
// A small first-in first-out buffer of classified requests.
// ============================================================================
module ntt_queue import ntt_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push_valid,
    output logic         push_ready,
    input  queue_entry_t push_entry,
    output logic         pop_valid,
    input  logic         pop_ready,
    output queue_entry_t pop_entry
);

    queue_entry_t      slots_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = slots_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
        bump = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (do_pop) begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

/* hdl/ntt_div.sv */
`timescale 1ns / 1ps
// ============================================================================
// ntt_div: serial restoring divider
// Divides the 24-bit scale by a 12-bit width, one quotient bit per cycle.
// ============================================================================
module ntt_div import ntt_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                 busy_reg, done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIST_W-1:0]    quo_reg;
    logic [COORD_W-1:0]   rem_reg, divisor_reg;
    logic [COORD_W:0]     trial;
    logic                 fits;

    assign trial = {rem_reg, quo_reg[DIST_W-1]};
    assign fits  = (trial >= {1'b0, divisor_reg});

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end else if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIST_W);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            rem_reg <= fits ? COORD_W'(trial - {1'b0, divisor_reg}) : COORD_W'(trial);
            quo_reg <= {quo_reg[DIST_W-2:0], fits};
        end else if (req.start) begin
            rem_reg     <= '0;
            quo_reg     <= req.dividend;
            divisor_reg <= req.divisor;
        end
    end

endmodule

/* hdl/ntt_back.sv */
`timescale 1ns / 1ps
// ============================================================================
// ntt_back: association and trajectory update
// Scores each box against the newest point and closes frames into results.
// ============================================================================
module ntt_back import ntt_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cfg_t                 cfg,
    input  logic                 pop_valid,
    output logic                 pop_ready,
    input  queue_entry_t         pop_entry,
    output div_req_t             div_req,
    input  div_rsp_t             div_rsp,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_DIFF,
        ST_SQUARE,
        ST_COMPARE,
        ST_FINISH
    } state_t;

    state_t               state_reg;
    item_kind_t           kind_reg;
    logic [POS_W-1:0]     cx_reg, cy_reg;
    logic [DIST_W-1:0]    cd_reg;
    logic [POS_W-1:0]     dx_reg, dy_reg;
    logic [DIST_W-1:0]    dd_reg;
    logic [1:0]           sq_cnt_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [GAP_W-1:0]     gap_reg, best_gap_reg;
    logic [POS_W-1:0]     best_x_reg, best_y_reg, lpx_reg, lpy_reg;
    logic [DIST_W-1:0]    best_d_reg, lpd_reg;
    logic [COUNT_W-1:0]   fbc_reg, miss_reg;
    logic [PH_W-1:0]      ph_reg;
    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;

    logic [DIST_W-1:0]    sq_op;
    logic                 added_next, cleared_next, valid_next, has_point;
    logic [COUNT_W-1:0]   miss_next;
    logic [PH_W-1:0]      ph_next;
    logic [POS_W-1:0]     lpx_next, lpy_next, tx_next, ty_next;
    logic [DIST_W-1:0]    lpd_next, td_next;
    logic [DEPTH_W-1:0]   depth_next;
    logic [CLASS_W-1:0]   class_next;
    logic                 slot_free;

    assign pop_ready = (state_reg == ST_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign slot_free = !m_valid_reg || m_tready;

    assign div_req.start    = (state_reg == ST_IDLE) && pop_valid &&
                              (pop_entry.kind != KIND_CLOSE);
    assign div_req.dividend = cfg.distance_scale;
    assign div_req.divisor  = pop_entry.width;

    // One shared squarer: distance term first, then x, then y.
    always_comb begin
        case (sq_cnt_reg)
            2'd0:    sq_op = dd_reg;
            2'd1:    sq_op = DIST_W'(dx_reg);
            2'd2:    sq_op = DIST_W'(dy_reg);
            default: sq_op = '0;
        endcase
    end

    // Frame close: miss counting, append, clearing and the reported point.
    always_comb begin
        added_next = (fbc_reg != '0) && ((fbc_reg == COUNT_W'(1)) || (ph_reg != '0));
        if (fbc_reg == '0) begin
            miss_next = (miss_reg == '1) ? miss_reg : miss_reg + 1'b1;
        end else begin
            miss_next = '0;
        end
        cleared_next = (miss_next > cfg.miss_limit);
        if (cleared_next) begin
            ph_next  = '0;
            lpx_next = '0;
            lpy_next = '0;
            lpd_next = '0;
        end else if (added_next) begin
            ph_next  = ph_reg + 1'b1;
            lpx_next = best_x_reg;
            lpy_next = best_y_reg;
            lpd_next = best_d_reg;
        end else begin
            ph_next  = ph_reg;
            lpx_next = lpx_reg;
            lpy_next = lpy_reg;
            lpd_next = lpd_reg;
        end
        has_point  = (ph_next != '0);
        valid_next = (fbc_reg != '0) && has_point;
        tx_next    = has_point ? lpx_next : '0;
        ty_next    = has_point ? lpy_next : '0;
        td_next    = has_point ? lpd_next : '0;
        depth_next = has_point ? ({1'b0, lpd_next} - {1'b0, cfg.depth_origin}) : '0;
        if (!has_point || (lpd_next < cfg.near_threshold)) begin
            class_next = CLASS_NEAR;
        end else if (lpd_next < cfg.mid_threshold) begin
            class_next = CLASS_MID;
        end else begin
            class_next = CLASS_FAR;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            fbc_reg      <= '0;
            miss_reg     <= '0;
            ph_reg       <= '0;
            lpx_reg      <= '0;
            lpy_reg      <= '0;
            lpd_reg      <= '0;
            best_gap_reg <= '0;
            sq_cnt_reg   <= '0;
        end else begin
            // The finish state refills the report slot itself.
            if (m_valid_reg && m_tready && (state_reg != ST_FINISH)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (pop_valid) begin
                        kind_reg <= pop_entry.kind;
                        cx_reg   <= pop_entry.cx;
                        cy_reg   <= pop_entry.cy;
                        // A full history drops its oldest point when a frame opens.
                        if ((fbc_reg == '0) && (ph_reg >= PH_W'(HISTORY_DEPTH))) begin
                            ph_reg <= PH_W'(HISTORY_DEPTH - 1);
                        end
                        state_reg <= (pop_entry.kind == KIND_CLOSE) ? ST_FINISH : ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_rsp.done) begin
                        cd_reg    <= div_rsp.quotient;
                        state_reg <= ST_DIFF;
                    end
                end
                ST_DIFF: begin
                    dx_reg     <= POS_W'(abs_diff(DIST_W'(cx_reg), DIST_W'(lpx_reg)));
                    dy_reg     <= POS_W'(abs_diff(DIST_W'(cy_reg), DIST_W'(lpy_reg)));
                    dd_reg     <= abs_diff(cd_reg, lpd_reg);
                    sq_cnt_reg <= '0;
                    state_reg  <= ST_SQUARE;
                end
                ST_SQUARE: begin
                    prod_reg   <= sq_op * sq_op;
                    sq_cnt_reg <= sq_cnt_reg + 1'b1;
                    if (sq_cnt_reg == 2'd1) begin
                        gap_reg <= GAP_W'(prod_reg);
                    end else if (sq_cnt_reg != 2'd0) begin
                        gap_reg <= gap_reg + GAP_W'(prod_reg);
                    end
                    if (sq_cnt_reg == 2'd3) begin
                        state_reg <= ST_COMPARE;
                    end
                end
                ST_COMPARE: begin
                    // Ties go to the later box.
                    if ((fbc_reg == '0) || (gap_reg <= best_gap_reg)) begin
                        best_x_reg   <= cx_reg;
                        best_y_reg   <= cy_reg;
                        best_d_reg   <= cd_reg;
                        best_gap_reg <= gap_reg;
                    end
                    if (fbc_reg != '1) begin
                        fbc_reg <= fbc_reg + 1'b1;
                    end
                    state_reg <= (kind_reg == KIND_BOX_LAST) ? ST_FINISH : ST_IDLE;
                end
                ST_FINISH: begin
                    if (slot_free) begin
                        miss_reg     <= miss_next;
                        ph_reg       <= ph_next;
                        lpx_reg      <= lpx_next;
                        lpy_reg      <= lpy_next;
                        lpd_reg      <= lpd_next;
                        fbc_reg      <= '0;
                        best_gap_reg <= '0;
                        m_valid_reg  <= 1'b1;
                        m_data_reg   <= {{(M_TDATA_W - OUT_FIELDS_W){1'b0}},
                                         valid_next, cleared_next, hist_len(ph_next),
                                         class_next, depth_next, td_next,
                                         ty_next, tx_next, added_next};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

/* hdl/nearest_target_tracker_top.sv */
`timescale 1ns / 1ps
// ============================================================================
// nearest_target_tracker_top: nearest-target track association
// Associates each frame's detection boxes with a trajectory and reports the
// newest track point, its depth and its distance class once per frame.
// ============================================================================
//
// Channel   Direction  Content
// s_*       in         one detection box request, or an empty-frame request
// m_*       out        one track report request per closed frame
// cfg_*     in         register writes: scale, miss limit, thresholds, origin
//
// A box request holds the back end while it leaves the queue, runs the serial
// divider, forms the differences, passes the shared squarer and the compare;
// closing a frame adds the finish state, and an empty request goes from idle to
// finish. The front register and a two-entry queue keep taking requests meanwhile,
// so the input stalls once both are full; a pending report holds the frame close.
// Reset is synchronous and active low and restores the register defaults.
//
module nearest_target_tracker_top import ntt_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input requests.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // box_x[11:0], box_y[23:12], box_width[35:24], box_height[47:36]
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // frame_empty[0]
    input  logic                  s_tuser,
    // last_in_frame
    input  logic                  s_tlast,
    // Result requests.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // point_added[0], track_x[13:1], track_y[26:14], track_distance[50:27],
    // track_depth[75:51], distance_class[77:76], history_length[82:78],
    // trajectory_cleared[83], track_valid[84], zero padding[87:85]
    output logic [M_TDATA_W-1:0]  m_tdata,
    // Configuration writes.
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t         cfg_reg;
    logic         push_valid, push_ready;
    queue_entry_t push_entry;
    logic         pop_valid, pop_ready;
    queue_entry_t pop_entry;
    div_req_t     div_req;
    div_rsp_t     div_rsp;

    // Configuration registers; writes to unused indexes are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.distance_scale <= RST_DISTANCE_SCALE;
            cfg_reg.miss_limit     <= RST_MISS_LIMIT;
            cfg_reg.near_threshold <= RST_NEAR_THRESHOLD;
            cfg_reg.mid_threshold  <= RST_MID_THRESHOLD;
            cfg_reg.depth_origin   <= RST_DEPTH_ORIGIN;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_DISTANCE_SCALE: cfg_reg.distance_scale <= cfg_wdata;
                REG_MISS_LIMIT:     cfg_reg.miss_limit     <= cfg_wdata[COUNT_W-1:0];
                REG_NEAR_THRESHOLD: cfg_reg.near_threshold <= cfg_wdata;
                REG_MID_THRESHOLD:  cfg_reg.mid_threshold  <= cfg_wdata;
                REG_DEPTH_ORIGIN:   cfg_reg.depth_origin   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Front end: registers and classifies each request, forms the box centre.
    ntt_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    // Queue that lets the front and back ends stall independently.
    ntt_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    // Serial divider for the per-box distance estimate.
    ntt_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Back end: gap scoring, nearest-box selection and frame close.
    ntt_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_entry (pop_entry),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

/* bench/nearest_target_tracker_checker.sv */
`timescale 1ns / 1ps
// ============================================================================
// nearest_target_tracker_checker: track report scoreboard
// Watches the box, report and register channels, predicts one track report
// per closed frame and compares each delivered report field by field.
// ============================================================================
module nearest_target_tracker_checker import ntt_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    // box_x[11:0], box_y[23:12], box_width[35:24], box_height[47:36]
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // frame_empty[0]
    input  logic                  s_tuser,
    input  logic                  s_tlast,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    // point_added[0], track_x[13:1], track_y[26:14], track_distance[50:27],
    // track_depth[75:51], distance_class[77:76], history_length[82:78],
    // trajectory_cleared[83], track_valid[84], zero padding[87:85]
    input  logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                    fail_count,
    output int                    pending_count
);

    // Field order matches the report bus, so a slice of m_tdata casts to it.
    typedef struct packed {
        logic               valid;
        logic               cleared;
        logic [HLEN_W-1:0]  hlen;
        logic [CLASS_W-1:0] cls;
        logic [DEPTH_W-1:0] depth;
        logic [DIST_W-1:0]  dist_mm;
        logic [POS_W-1:0]   y;
        logic [POS_W-1:0]   x;
        logic               added;
    } track_report_t;

    track_report_t expected_reports[$];
    int            report_index;

    logic [DIST_W-1:0]  cfg_scale;
    logic [COUNT_W-1:0] cfg_miss_limit;
    logic [DIST_W-1:0]  cfg_near;
    logic [DIST_W-1:0]  cfg_mid;
    logic [DIST_W-1:0]  cfg_origin;

    logic [POS_W-1:0]   point_x;
    logic [POS_W-1:0]   point_y;
    logic [DIST_W-1:0]  point_dist;
    logic [7:0]         points_held;
    logic [COUNT_W-1:0] misses;
    logic [COUNT_W-1:0] boxes_seen;
    logic [POS_W-1:0]   best_x;
    logic [POS_W-1:0]   best_y;
    logic [DIST_W-1:0]  best_dist;
    logic [63:0]        best_gap;

    initial begin
        fail_count    = 0;
        pending_count = 0;
        report_index  = 0;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] report %0d: %s got 0x%0h expected 0x%0h",
                 $time, report_index, what, got, want);
        fail_count++;
    endtask

    function automatic logic [63:0] gap_term(input logic [DIST_W-1:0] a,
                                             input logic [DIST_W-1:0] b);
        logic [63:0] d;
        d = (a > b) ? 64'(a - b) : 64'(b - a);
        return d * d;
    endfunction

    task automatic apply_write(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] value);
        case (idx)
            REG_DISTANCE_SCALE: cfg_scale      = value;
            REG_MISS_LIMIT:     cfg_miss_limit = value[COUNT_W-1:0];
            REG_NEAR_THRESHOLD: cfg_near       = value;
            REG_MID_THRESHOLD:  cfg_mid        = value;
            REG_DEPTH_ORIGIN:   cfg_origin     = value;
            default: ;
        endcase
    endtask

    // Folds one accepted request into the frame; a frame close queues a report.
    task automatic associate_request(input logic empty, input logic [COORD_W-1:0] bx,
                                     input logic [COORD_W-1:0] by,
                                     input logic [COORD_W-1:0] bw,
                                     input logic [COORD_W-1:0] bh, input logic last);
        logic [POS_W-1:0]  cx;
        logic [POS_W-1:0]  cy;
        logic [DIST_W-1:0] cd;
        logic [63:0]       gap;
        track_report_t     rep;
        if (boxes_seen == 0 && points_held >= HISTORY_DEPTH) begin
            points_held = 8'(HISTORY_DEPTH - 1);
        end
        if (!empty) begin
            cx  = POS_W'(bx) + POS_W'(bw >> 1);
            cy  = POS_W'(by) + POS_W'(bh >> 1);
            cd  = cfg_scale / ((bw == 0) ? DIST_W'(1) : DIST_W'(bw));
            gap = gap_term(DIST_W'(cx), DIST_W'(point_x)) +
                  gap_term(DIST_W'(cy), DIST_W'(point_y)) + gap_term(cd, point_dist);
            // Ties go to the later box.
            if (boxes_seen == 0 || gap <= best_gap) begin
                best_x    = cx;
                best_y    = cy;
                best_dist = cd;
                best_gap  = gap;
            end
            if (boxes_seen != 8'hFF) begin
                boxes_seen++;
            end
        end
        if (empty || last) begin
            rep = '0;
            if (boxes_seen == 0) begin
                if (misses != 8'hFF) begin
                    misses++;
                end
            end else begin
                misses = '0;
                if (boxes_seen == 1 || points_held > 0) begin
                    point_x    = best_x;
                    point_y    = best_y;
                    point_dist = best_dist;
                    points_held++;
                    rep.added  = 1'b1;
                end
            end
            if (misses > cfg_miss_limit) begin
                points_held = '0;
                point_x     = '0;
                point_y     = '0;
                point_dist  = '0;
                rep.cleared = 1'b1;
            end
            rep.valid = (boxes_seen > 0) && (points_held > 0);
            if (points_held > 0) begin
                rep.x       = point_x;
                rep.y       = point_y;
                rep.dist_mm = point_dist;
                rep.depth   = {1'b0, point_dist} - {1'b0, cfg_origin};
                if (point_dist < cfg_near) begin
                    rep.cls = CLASS_NEAR;
                end else if (point_dist < cfg_mid) begin
                    rep.cls = CLASS_MID;
                end else begin
                    rep.cls = CLASS_FAR;
                end
            end
            rep.hlen = (points_held > 31) ? HLEN_W'(31) : points_held[HLEN_W-1:0];
            expected_reports.insert(expected_reports.size(), rep);
            boxes_seen = '0;
            best_x     = '0;
            best_y     = '0;
            best_dist  = '0;
            best_gap   = '0;
        end
    endtask

    task automatic check_report(input track_report_t got);
        track_report_t want;
        if (expected_reports.size() == 0) begin
            report_mismatch("report with none expected", 64'(got), 64'd0);
        end else begin
            want = expected_reports.pop_front();
            if (got.added !== want.added)
                report_mismatch("point_added", 64'(got.added), 64'(want.added));
            if (got.x !== want.x)
                report_mismatch("track_x", 64'(got.x), 64'(want.x));
            if (got.y !== want.y)
                report_mismatch("track_y", 64'(got.y), 64'(want.y));
            if (got.dist_mm !== want.dist_mm)
                report_mismatch("track_distance", 64'(got.dist_mm), 64'(want.dist_mm));
            if (got.depth !== want.depth)
                report_mismatch("track_depth", 64'(got.depth), 64'(want.depth));
            if (got.cls !== want.cls)
                report_mismatch("distance_class", 64'(got.cls), 64'(want.cls));
            if (got.hlen !== want.hlen)
                report_mismatch("history_length", 64'(got.hlen), 64'(want.hlen));
            if (got.cleared !== want.cleared)
                report_mismatch("trajectory_cleared", 64'(got.cleared),
                                64'(want.cleared));
            if (got.valid !== want.valid)
                report_mismatch("track_valid", 64'(got.valid), 64'(want.valid));
        end
        report_index++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg_scale      = RST_DISTANCE_SCALE;
            cfg_miss_limit = RST_MISS_LIMIT;
            cfg_near       = RST_NEAR_THRESHOLD;
            cfg_mid        = RST_MID_THRESHOLD;
            cfg_origin     = RST_DEPTH_ORIGIN;
            point_x        = '0;
            point_y        = '0;
            point_dist     = '0;
            points_held    = '0;
            misses         = '0;
            boxes_seen     = '0;
            best_x         = '0;
            best_y         = '0;
            best_dist      = '0;
            best_gap       = '0;
            expected_reports.delete();
        end else begin
            // Reports are checked before this edge's request is folded in.
            if (m_tvalid && m_tready) begin
                check_report(m_tdata[OUT_FIELDS_W-1:0]);
            end
            if (cfg_wr_en) begin
                apply_write(cfg_index, cfg_wdata);
            end
            if (s_tvalid && s_tready) begin
                associate_request(s_tuser, s_tdata[11:0], s_tdata[23:12],
                                  s_tdata[35:24], s_tdata[47:36], s_tlast);
            end
        end
        pending_count = expected_reports.size();
    end

endmodule

/* bench/tb_nearest_target_tracker_top.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_nearest_target_tracker_top: regression bench of the nearest target tracker
// Drives directed and random detection frames under several register settings
// with bursty input and a stalling report sink; a checker module predicts and
// compares every track report, and this module gives the verdict.
// ============================================================================
module tb_nearest_target_tracker_top;
    import ntt_pkg::*;

    // The settle time after the last report covers a box still in flight plus
    // the frame close.
    localparam int SETTLE_CYCLES = 100;
    localparam int CYCLE_LIMIT   = 600000;

    // Report sink behaviors.
    localparam int RX_OPEN   = 0;
    localparam int RX_COIN   = 1;
    localparam int RX_SPARSE = 2;
    localparam int RX_LONG   = 3;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int fail_count;
    int pending_count;
    int cycle_count = 0;
    int burst_left  = 0;
    int rx_mode     = RX_OPEN;
    int rx_left     = 0;
    int rx_tick     = 0;

    nearest_target_tracker_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    nearest_target_tracker_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial begin
        aclk = 1'b0;
    end

    always #1 aclk = ~aclk;

    // Watchdog: a hung handshake or a lost report ends the run here.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // The report sink switches at random between behaviors: always ready, a coin
    // toss per cycle, rare stalls, or long regular stalls. Like all inputs, m_tready
    // moves only on the falling edge.
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(RX_LONG, RX_OPEN);
            rx_left = $urandom_range(600, 50);
        end
        rx_left--;
        rx_tick++;
        case (rx_mode)
            RX_OPEN:   m_tready = 1'b1;
            RX_COIN:   m_tready = 1'($urandom_range(1, 0));
            RX_SPARSE: m_tready = ($urandom_range(7, 0) != 0);
            default:   m_tready = ((rx_tick % 37) >= 30);
        endcase
    end

    // Any 12-bit value, for fields the block ignores or takes at full range.
    function automatic logic [COORD_W-1:0] rand_field();
        return COORD_W'($urandom_range(4095, 0));
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom_range(1, 0));
    endfunction

    // Box coordinates favor the edges of the 12-bit range now and then.
    function automatic logic [COORD_W-1:0] pick_coord();
        int r;
        r = $urandom_range(99, 0);
        if (r < 5) return '0;
        if (r < 10) return '1;
        return COORD_W'($urandom_range(4095, 0));
    endfunction

    // Widths lean small so that distances spread over the whole 24-bit range;
    // a zero width is sent too, which the block treats as one.
    function automatic logic [COORD_W-1:0] pick_width();
        int r;
        r = $urandom_range(99, 0);
        if (r < 3) return '0;
        if (r < 8) return '1;
        if (r < 40) return COORD_W'($urandom_range(64, 1));
        return COORD_W'($urandom_range(4095, 1));
    endfunction

    // Sends one request and holds it until the block takes it. The sender
    // works in bursts; when a burst runs out it idles for a random gap.
    task automatic send_request(input logic empty, input logic [COORD_W-1:0] bx,
                                input logic [COORD_W-1:0] by,
                                input logic [COORD_W-1:0] bw,
                                input logic [COORD_W-1:0] bh, input logic last);
        int r;
        int gap;
        if (burst_left == 0) begin
            r   = $urandom_range(99, 0);
            gap = (r < 30) ? 0 : (r < 80) ? $urandom_range(4, 1) : $urandom_range(25, 5);
            repeat (gap) begin
                @(negedge aclk);
                s_tvalid = 1'b0;
            end
            burst_left = $urandom_range(40, 1);
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser  = empty;
        s_tlast  = last;
        s_tdata  = {bh, bw, by, bx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Parks the sender until every expected report is in, then lets the
    // block sit for extra cycles so that nothing is left in flight.
    task automatic wait_drained(input int extra);
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (extra) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        @(posedge aclk);
    endtask

    task automatic set_config(input logic [DIST_W-1:0] scale,
                              input logic [COUNT_W-1:0] limit,
                              input logic [DIST_W-1:0] near_mm,
                              input logic [DIST_W-1:0] mid_mm,
                              input logic [DIST_W-1:0] origin);
        write_reg(REG_DISTANCE_SCALE, scale);
        write_reg(REG_MISS_LIMIT, CFG_DATA_W'(limit));
        write_reg(REG_NEAR_THRESHOLD, near_mm);
        write_reg(REG_MID_THRESHOLD, mid_mm);
        write_reg(REG_DEPTH_ORIGIN, origin);
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // Random frames. Most are well formed: one box, or a few with the last
    // one marked. The rest are empty frames with random payload and tlast,
    // and frames of unmarked boxes that an empty request closes. Now and then
    // the sender waits for the block to drain completely.
    task automatic run_traffic(input int count);
        int sent;
        int kind;
        int boxes;
        sent = 0;
        while (sent < count) begin
            kind = $urandom_range(99, 0);
            if (kind < 12) begin
                send_request(1'b1, rand_field(), rand_field(), rand_field(), rand_field(),
                             rand_bit());
                sent++;
            end else begin
                boxes = ($urandom_range(99, 0) < 55) ? 1 : $urandom_range(5, 2);
                for (int i = 0; i < boxes; i++) begin
                    send_request(1'b0, pick_coord(), pick_coord(), pick_width(),
                                 pick_coord(), (kind >= 16) && (i == boxes - 1));
                    sent++;
                end
                if (kind < 16) begin
                    send_request(1'b1, rand_field(), rand_field(), rand_field(),
                                 rand_field(), rand_bit());
                    sent++;
                end
            end
            if ($urandom_range(99, 0) < 3) begin
                wait_drained(0);
            end
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        s_tlast   = 1'b0;
        m_tready  = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed frames under the default scale, with a miss limit of one so
        // that two empty frames clear the trajectory.
        write_reg(REG_MISS_LIMIT, CFG_DATA_W'(1));
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        // Two boxes with no history: nothing may be appended.
        send_request(1'b0, 12'd100, 12'd100, 12'd50, 12'd50, 1'b0);
        send_request(1'b0, 12'd300, 12'd200, 12'd20, 12'd10, 1'b1);
        // A single box always starts the trajectory, at centre (125, 125).
        send_request(1'b0, 12'd100, 12'd100, 12'd50, 12'd50, 1'b1);
        // Two boxes at the same gap from that point: the later one must win.
        send_request(1'b0, 12'd90, 12'd100, 12'd50, 12'd50, 1'b0);
        send_request(1'b0, 12'd110, 12'd100, 12'd50, 12'd50, 1'b1);
        // Zero width counts as width one; then the field extremes.
        send_request(1'b0, 12'd4095, 12'd0, 12'd0, 12'd4095, 1'b1);
        send_request(1'b0, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b1);
        send_request(1'b0, 12'd0, 12'd0, 12'd1, 12'd1, 1'b1);
        // An empty request closes a frame of unmarked boxes.
        send_request(1'b0, 12'd10, 12'd20, 12'd30, 12'd40, 1'b0);
        send_request(1'b1, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0);
        // Two misses go past the limit and clear; a third reports from an
        // empty history.
        send_request(1'b1, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b1);
        send_request(1'b1, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0);
        send_request(1'b1, 12'd0, 12'd0, 12'd0, 12'd0, 1'b1);
        // A fresh start after the clear.
        send_request(1'b0, 12'd2048, 12'd2048, 12'd2048, 12'd2048, 1'b1);
        wait_drained(SETTLE_CYCLES);

        // Largest scale and mid threshold, zero near threshold and origin, miss limit three.
        set_config(24'hFFFFFF, 8'd3, 24'd0, 24'hFFFFFF, 24'd0);
        run_traffic(60);
        wait_drained(SETTLE_CYCLES);

        // Smallest scale and miss limit, largest origin, thresholds swapped.
        set_config(24'd1, 8'd0, 24'hFFFFFF, 24'd0, 24'hFFFFFF);
        run_traffic(60);
        wait_drained(SETTLE_CYCLES);

        // A random setting.
        set_config(DIST_W'($urandom_range(24'hFFFFFF, 1)), COUNT_W'($urandom_range(255, 0)),
                   DIST_W'($urandom_range(24'hFFFFFF, 0)),
                   DIST_W'($urandom_range(24'hFFFFFF, 0)),
                   DIST_W'($urandom_range(24'hFFFFFF, 0)));
        run_traffic(60);
        wait_drained(SETTLE_CYCLES);

        // A long run of empty frames: the miss counter must stop at its top
        // value instead of wrapping, so every frame past the limit clears.
        // Then one frame of 257 boxes with an empty history, which must not
        // look like a single-box frame to the box counter.
        set_config(24'd90000, 8'd254, 24'd300, 24'd550, 24'd500);
        repeat (260) begin
            send_request(1'b1, rand_field(), rand_field(), rand_field(), rand_field(),
                         rand_bit());
        end
        for (int i = 0; i < 257; i++) begin
            send_request(1'b0, pick_coord(), pick_coord(), pick_width(), pick_coord(),
                         i == 256);
        end
        wait_drained(SETTLE_CYCLES);

        // Largest miss limit with moderate thresholds, so that a long
        // trajectory fills the history.
        set_config(24'd90000, 8'd255, DIST_W'($urandom_range(2000, 0)),
                   DIST_W'($urandom_range(20000, 0)),
                   DIST_W'($urandom_range(24'hFFFFFF, 0)));
        run_traffic(60);
        wait_drained(SETTLE_CYCLES);

        if (fail_count == 0 && pending_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* filelist.f */
hdl/ntt_pkg.sv
hdl/ntt_front.sv
hdl/ntt_queue.sv
hdl/ntt_div.sv
hdl/ntt_back.sv
hdl/nearest_target_tracker_top.sv
bench/nearest_target_tracker_checker.sv
bench/tb_nearest_target_tracker_top.sv
